/* hw/rtl/sensor_packet_supervisor_defines.svh */
// Assertion macros for the sensor packet supervisor.
// Included by the RTL files that carry assertions; depends on nothing.
`ifndef SENSOR_PACKET_SUPERVISOR_DEFINES_SVH
`define SENSOR_PACKET_SUPERVISOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SPS_ASSERT_IMPL(name, clk_i, rst_ni, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sensor_packet_supervisor: same-cycle check failed");

// Next-cycle implication
`define SPS_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sensor_packet_supervisor: next-cycle check failed");

`else

`define SPS_ASSERT_IMPL(name, clk_i, rst_ni, ante, cons)
`define SPS_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons)

`endif

`endif

/* hw/rtl/spsup_pkg.sv */
// Shared types and constants for the sensor packet supervisor.
// No dependencies; used by every RTL module of the block.
package spsup_pkg;

  // Field widths
  localparam int DIST_W     = 16;
  localparam int SMP_W      = 12;
  localparam int ID_W       = 32;
  localparam int SUM_W      = 17;
  // Band thresholds are sample-scale values times the window length (up to 32)
  localparam int THR_W      = SUM_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int WINDOW_DEF = 20;

  // Register reset values
  localparam logic [DIST_W-1:0] TRIG_RST   = 16'd30;
  localparam logic [SMP_W-1:0]  VLOW_RST   = 12'd700;
  localparam logic [SMP_W-1:0]  VHIGH_RST  = 12'd4000;
  localparam logic [SMP_W-1:0]  SUBST_RST  = 12'd3300;
  localparam logic [SMP_W-1:0]  LOWLVL_RST = 12'd2600;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER    = 3'd0,
    REG_VALID_LOW  = 3'd1,
    REG_VALID_HIGH = 3'd2,
    REG_SUBSTITUTE = 3'd3,
    REG_LOW_LEVEL  = 3'd4
  } cfg_reg_t;

  // Obstacle report codes
  typedef enum logic [1:0] {
    OBS_NONE  = 2'd0,
    OBS_FRONT = 2'd1,
    OBS_LEFT  = 2'd2,
    OBS_RIGHT = 2'd3
  } obstacle_t;

  // Settings as seen by the evaluation logic
  typedef struct packed {
    logic [DIST_W-1:0] trigger;
    logic [SMP_W-1:0]  valid_low;
    logic [SMP_W-1:0]  valid_high;
    logic [SMP_W-1:0]  substitute;
    logic [THR_W-1:0]  band_lo_thr;  // (valid_low + 1) * WINDOW
    logic [THR_W-1:0]  band_hi_thr;  // low_battery_level * WINDOW
  } cfg_t;

  // One result word
  typedef struct packed {
    logic      fresh;
    obstacle_t obstacle;
    logic      low_battery;
  } result_t;

endpackage

/* hw/rtl/spsup_cfg.sv */
// Configuration registers of the sensor packet supervisor.
// Depends on spsup_pkg; also keeps the window-scaled battery band thresholds.
module spsup_cfg #(
  parameter int WINDOW = spsup_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [spsup_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spsup_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output spsup_pkg::cfg_t                     cfg
);

  localparam int THR_W = spsup_pkg::THR_W;
  localparam int SMP_W = spsup_pkg::SMP_W;

  localparam logic [THR_W-1:0] LO_THR_RST =
    THR_W'((int'(spsup_pkg::VLOW_RST) + 1) * WINDOW);
  localparam logic [THR_W-1:0] HI_THR_RST =
    THR_W'(int'(spsup_pkg::LOWLVL_RST) * WINDOW);

  spsup_pkg::cfg_t cfg_r;

  // avg > low  <=>  sum >= (low + 1) * WINDOW ;  avg < level  <=>  sum < level * WINDOW
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger     <= spsup_pkg::TRIG_RST;
      cfg_r.valid_low   <= spsup_pkg::VLOW_RST;
      cfg_r.valid_high  <= spsup_pkg::VHIGH_RST;
      cfg_r.substitute  <= spsup_pkg::SUBST_RST;
      cfg_r.band_lo_thr <= LO_THR_RST;
      cfg_r.band_hi_thr <= HI_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spsup_pkg::REG_TRIGGER: begin
          cfg_r.trigger <= cfg_wdata[spsup_pkg::DIST_W-1:0];
        end
        spsup_pkg::REG_VALID_LOW: begin
          cfg_r.valid_low   <= cfg_wdata[SMP_W-1:0];
          cfg_r.band_lo_thr <= (THR_W'(cfg_wdata[SMP_W-1:0]) + THR_W'(1)) * THR_W'(WINDOW);
        end
        spsup_pkg::REG_VALID_HIGH: begin
          cfg_r.valid_high <= cfg_wdata[SMP_W-1:0];
        end
        spsup_pkg::REG_SUBSTITUTE: begin
          cfg_r.substitute <= cfg_wdata[SMP_W-1:0];
        end
        spsup_pkg::REG_LOW_LEVEL: begin
          cfg_r.band_hi_thr <= THR_W'(cfg_wdata[SMP_W-1:0]) * THR_W'(WINDOW);
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/spsup_eval.sv */
// Per-packet evaluation and supervisor state (id, confirm flag, battery window).
// Depends on spsup_pkg and sensor_packet_supervisor_defines.svh.
`include "sensor_packet_supervisor_defines.svh"

module spsup_eval #(
  parameter int WINDOW = spsup_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spsup_pkg::cfg_t                   cfg,
  input  logic                              adv,
  input  logic [spsup_pkg::DIST_W-1:0]      us_front,
  input  logic [spsup_pkg::DIST_W-1:0]      us_left,
  input  logic [spsup_pkg::DIST_W-1:0]      us_right,
  input  logic [spsup_pkg::SMP_W-1:0]       battery_sample,
  input  logic [spsup_pkg::ID_W-1:0]        seq_id,
  output spsup_pkg::result_t                res
);

  localparam int SUM_W = spsup_pkg::SUM_W;
  localparam int THR_W = spsup_pkg::THR_W;
  localparam int CNT_W = $clog2(WINDOW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);

  logic                          pending_r, pending_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [spsup_pkg::ID_W-1:0]    prev_id_r, prev_id_nxt;

  spsup_pkg::obstacle_t          hit;
  logic                          sample_ok;
  logic [SUM_W-1:0]              add_val;
  logic [THR_W-1:0]              sum_ext;

  // Fixed-priority obstacle: front, then left, then right
  always_comb begin
    if (us_front < cfg.trigger) begin
      hit = spsup_pkg::OBS_FRONT;
    end else if (us_left < cfg.trigger) begin
      hit = spsup_pkg::OBS_LEFT;
    end else if (us_right < cfg.trigger) begin
      hit = spsup_pkg::OBS_RIGHT;
    end else begin
      hit = spsup_pkg::OBS_NONE;
    end
  end

  // Battery sample qualification
  assign sample_ok = (battery_sample < cfg.valid_high) && (battery_sample > cfg.valid_low);
  assign add_val   = sample_ok ? SUM_W'(battery_sample) : SUM_W'(cfg.substitute);
  assign sum_ext   = THR_W'(sum_r);

  // Result and next state
  always_comb begin
    pending_nxt     = pending_r;
    cnt_nxt         = cnt_r;
    sum_nxt         = sum_r;
    prev_id_nxt     = seq_id;
    res.fresh       = seq_id > prev_id_r;
    res.obstacle    = spsup_pkg::OBS_NONE;
    res.low_battery = 1'b0;
    if (res.fresh) begin
      if (hit != spsup_pkg::OBS_NONE) begin
        if (!pending_r) begin
          pending_nxt = 1'b1;
        end else begin
          pending_nxt  = 1'b0;
          res.obstacle = hit;
        end
      end
      // window end: judge the average, drop this sample, restart
      if (cnt_r == CNT_LAST) begin
        res.low_battery = (sum_ext < cfg.band_hi_thr) && (sum_ext >= cfg.band_lo_thr);
        sum_nxt         = '0;
        cnt_nxt         = '0;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        sum_nxt = sum_r + add_val;
      end
    end
  end

  // State registers advance once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      cnt_r     <= '0;
      sum_r     <= '0;
      prev_id_r <= '0;
    end else if (adv) begin
      pending_r <= pending_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      prev_id_r <= prev_id_nxt;
    end
  end

  `SPS_ASSERT_IMPL(a_cnt_in_window, clk, rst_n, 1'b1, cnt_r <= CNT_LAST)
  `SPS_ASSERT_IMPL(a_event_needs_pending, clk, rst_n,
                   res.obstacle != spsup_pkg::OBS_NONE, pending_r)
  `SPS_ASSERT_IMPL(a_low_at_window_end, clk, rst_n,
                   res.low_battery, res.fresh && (cnt_r == CNT_LAST))
  `SPS_ASSERT_NEXT(a_stale_keeps_state, clk, rst_n, adv && !res.fresh,
                   $stable(cnt_r) && $stable(sum_r) && $stable(pending_r))

endmodule

/* hw/rtl/sensor_packet_supervisor.sv */
// Top level of the sensor packet supervisor: input register, evaluation, result register.
// Depends on spsup_pkg, spsup_cfg and spsup_eval.
//
// Takes one sensor packet word per clock while out_ready is high and returns exactly one
// result word per packet, in order. A packet waits in the input register while the
// evaluation logic compares it against the last id, the trigger distance and the
// battery window, and the result lands in the output register when the word moves on,
// which is when the result register is free or drains; out_valid then rises, and
// throughput is one word per cycle while out_ready is high. The input register takes
// one more word while a finished result waits. Register writes on the cfg_ port take
// effect at the next edge; the battery band thresholds are stored pre-multiplied by
// WINDOW, so the window average needs no divider.
module sensor_packet_supervisor #(
  parameter int WINDOW = spsup_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [spsup_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spsup_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // packet input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spsup_pkg::DIST_W-1:0]      in_us_front,
  input  logic [spsup_pkg::DIST_W-1:0]      in_us_left,
  input  logic [spsup_pkg::DIST_W-1:0]      in_us_right,
  input  logic [spsup_pkg::SMP_W-1:0]       in_battery_sample,
  input  logic [spsup_pkg::ID_W-1:0]        in_seq_id,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_fresh,
  output logic [1:0]                        out_obstacle_event,
  output logic                              out_low_battery
);

  spsup_pkg::cfg_t                  cfg;
  spsup_pkg::result_t               res;

  logic                             s1_valid_r;
  logic [spsup_pkg::DIST_W-1:0]     s1_front_r;
  logic [spsup_pkg::DIST_W-1:0]     s1_left_r;
  logic [spsup_pkg::DIST_W-1:0]     s1_right_r;
  logic [spsup_pkg::SMP_W-1:0]      s1_sample_r;
  logic [spsup_pkg::ID_W-1:0]       s1_id_r;
  logic                             s1_adv;

  logic                             out_valid_r;
  spsup_pkg::result_t               out_res_r;

  spsup_cfg #(
    .WINDOW (WINDOW)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline flow: a word moves on when the result register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_front_r  <= in_us_front;
      s1_left_r   <= in_us_left;
      s1_right_r  <= in_us_right;
      s1_sample_r <= in_battery_sample;
      s1_id_r     <= in_seq_id;
    end
  end

  spsup_eval #(
    .WINDOW (WINDOW)
  ) u_eval (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .adv            (s1_adv),
    .us_front       (s1_front_r),
    .us_left        (s1_left_r),
    .us_right       (s1_right_r),
    .battery_sample (s1_sample_r),
    .seq_id         (s1_id_r),
    .res            (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fresh          = out_res_r.fresh;
  assign out_obstacle_event = out_res_r.obstacle;
  assign out_low_battery    = out_res_r.low_battery;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for sensor_packet_supervisor: directed packet table, then
// randomized phases under several register settings with random backpressure.
// Depends on spsup_pkg and the sensor_packet_supervisor RTL only.
module testbench;
  import spsup_pkg::*;

  localparam int WINDOW          = WINDOW_DEF;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DIRECTED_ROWS   = 25;

  localparam logic [DIST_W-1:0] FAR  = 16'd1000;
  localparam logic [DIST_W-1:0] DMAX = 16'hFFFF;

  // Common result words for the directed table
  localparam result_t STALE = '{1'b0, OBS_NONE, 1'b0};
  localparam result_t QUIET = '{1'b1, OBS_NONE, 1'b0};

  typedef struct packed {
    logic [DIST_W-1:0] front;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] right;
    logic [SMP_W-1:0]  sample;
    logic [ID_W-1:0]   id;
  } sensor_packet_t;

  typedef struct packed {
    logic [DIST_W-1:0] trigger;
    logic [SMP_W-1:0]  valid_low;
    logic [SMP_W-1:0]  valid_high;
    logic [SMP_W-1:0]  substitute;
    logic [SMP_W-1:0]  low_level;
  } settings_t;

  typedef struct {
    sensor_packet_t pkt;
    bit             typed;  // expected word typed in below, else from the model
    result_t        want;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [DIST_W-1:0]     in_us_front;
  logic [DIST_W-1:0]     in_us_left;
  logic [DIST_W-1:0]     in_us_right;
  logic [SMP_W-1:0]      in_battery_sample;
  logic [ID_W-1:0]       in_seq_id;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_fresh;
  logic [1:0]            out_obstacle_event;
  logic                  out_low_battery;

  sensor_packet_supervisor #(.WINDOW(WINDOW)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_us_front       (in_us_front),
    .in_us_left        (in_us_left),
    .in_us_right       (in_us_right),
    .in_battery_sample (in_battery_sample),
    .in_seq_id         (in_seq_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_fresh         (out_fresh),
    .out_obstacle_event(out_obstacle_event),
    .out_low_battery   (out_low_battery)
  );

  // Directed packets, all under reset settings (trigger 30, band 700..4000)
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{16'd0, 16'd0, 16'd0, 12'd0, 32'd0}, 1'b1, STALE},        // id equals reset id
    '{'{16'd0, FAR, FAR, 12'd0, 32'd1}, 1'b1, QUIET},            // first sighting arms
    '{'{FAR, 16'd5, FAR, 12'd4095, 32'd2}, 1'b1, '{1'b1, OBS_LEFT, 1'b0}},
    '{'{16'd0, 16'd0, 16'd0, 12'd1000, 32'd2}, 1'b1, STALE},     // repeated id
    '{'{16'd0, 16'd0, 16'd0, 12'd1000, 32'd1}, 1'b1, STALE},     // older id
    '{'{DMAX, DMAX, DMAX, 12'd700, 32'd3}, 1'b1, QUIET},
    '{'{DMAX, DMAX, 16'd29, 12'd4000, 32'd4}, 1'b1, QUIET},      // arms on right
    '{'{16'd30, 16'd30, 16'd30, 12'd701, 32'd5}, 1'b1, QUIET},   // at trigger, flag held
    '{'{DMAX, DMAX, 16'd0, 12'd3999, 32'd6}, 1'b1, '{1'b1, OBS_RIGHT, 1'b0}},
    '{'{16'd29, 16'd0, 16'd0, 12'd1000, 32'd7}, 1'b1, QUIET},
    '{'{16'd0, 16'd0, 16'd0, 12'd1000, 32'd7}, 1'b1, STALE},     // stale cannot confirm
    '{'{16'd0, 16'd0, 16'd0, 12'd1000, 32'd8}, 1'b1, '{1'b1, OBS_FRONT, 1'b0}},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd9}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd10}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd11}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd12}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd13}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd14}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd15}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd16}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd17}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd18}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd1000, 32'd19}, 1'b0, STALE},
    '{'{FAR, FAR, FAR, 12'd4095, 32'hFFFF_FFFE}, 1'b0, STALE},  // window closes, low avg
    '{'{16'd0, FAR, FAR, 12'd1000, 32'hFFFF_FFFF}, 1'b0, STALE}
  };

  // Mirror of the block settings and state
  logic [DIST_W-1:0] trig_dist    = TRIG_RST;
  logic [SMP_W-1:0]  valid_low    = VLOW_RST;
  logic [SMP_W-1:0]  valid_high   = VHIGH_RST;
  logic [SMP_W-1:0]  substitute   = SUBST_RST;
  logic [SMP_W-1:0]  low_level    = LOWLVL_RST;
  logic              confirm_armed = 1'b0;
  logic [4:0]        window_fill   = '0;
  logic [SUM_W-1:0]  battery_total = '0;
  logic [ID_W-1:0]   last_id       = '0;

  logic [ID_W-1:0] last_sent_id = '0;
  result_t         pending_results[$];
  int              mismatches  = 0;
  int              result_idx  = 0;
  int              cycle_count = 0;
  bit              in_idle_on  = 1'b1;
  bit              out_stall_on = 1'b1;

  // Expected word for one packet; advances the mirrored state
  function automatic result_t supervise_packet(sensor_packet_t p);
    result_t          r;
    obstacle_t        hit;
    logic [SMP_W-1:0] add;
    int unsigned      avg;
    r = STALE;
    r.fresh = (p.id > last_id);
    if (r.fresh) begin
      if (p.front < trig_dist) hit = OBS_FRONT;
      else if (p.left < trig_dist) hit = OBS_LEFT;
      else if (p.right < trig_dist) hit = OBS_RIGHT;
      else hit = OBS_NONE;
      if (hit != OBS_NONE) begin
        if (!confirm_armed) begin
          confirm_armed = 1'b1;
        end else begin
          confirm_armed = 1'b0;
          r.obstacle = hit;
        end
      end
      // closing packet of a window checks the average and drops its own sample
      if (int'(window_fill) + 1 >= WINDOW) begin
        avg = battery_total / WINDOW;
        r.low_battery = (avg < low_level) && (avg > valid_low);
        battery_total = '0;
        window_fill = '0;
      end else begin
        window_fill = window_fill + 5'd1;
        add = (p.sample < valid_high && p.sample > valid_low) ? p.sample : substitute;
        battery_total = battery_total + SUM_W'(add);
      end
    end
    last_id = p.id;
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: return DIST_W'($urandom);
      1: return (trig_dist == '0) ? '0 : DIST_W'($urandom_range(trig_dist - 1, 0));
      2: return trig_dist;
      3: return '1;
      default: return (trig_dist == '1) ? trig_dist :
                      DIST_W'($urandom_range(DMAX, trig_dist + 1));
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0: return SMP_W'($urandom);
      1: return valid_low;
      2: return valid_high;
      3: return valid_low + 1'b1;
      4: return valid_high - 1'b1;
      default: return SMP_W'($urandom_range(low_level, valid_low));  // mostly inside the band
    endcase
  endfunction

  // Mostly rising ids; some repeats, older ids and wild jumps
  function automatic sensor_packet_t random_packet();
    sensor_packet_t p;
    int unsigned    mode;
    mode = $urandom_range(0, 99);
    if (mode < 80) p.id = last_sent_id + $urandom_range(1, 4);
    else if (mode < 85) p.id = last_sent_id;
    else if (mode < 90) p.id = last_sent_id - $urandom_range(1, 3);
    else if (mode < 95) p.id = $urandom;
    else p.id = last_sent_id + $urandom_range(1, 32'h00FF_FFFF);
    last_sent_id = p.id;
    p.front  = pick_distance();
    p.left   = pick_distance();
    p.right  = pick_distance();
    p.sample = pick_sample();
    return p;
  endfunction

  function automatic settings_t phase_settings(int ph);
    settings_t s;
    case (ph)
      0: s = '{16'd0, 12'd0, 12'd4095, 12'd0, 12'd4095};
      1: s = '{16'hFFFF, 12'd4095, 12'd0, 12'd4095, 12'd0};
      2: s = '{16'd1000, 12'd1000, 12'd3000, 12'd500, 12'd2000};
      5: s = '{TRIG_RST, VLOW_RST, VHIGH_RST, SUBST_RST, LOWLVL_RST};
      default: begin
        s.trigger    = DIST_W'($urandom_range(0, 2000));
        s.valid_low  = SMP_W'($urandom_range(0, 2047));
        s.valid_high = SMP_W'($urandom_range(2048, 4095));
        s.substitute = SMP_W'($urandom);
        s.low_level  = SMP_W'($urandom_range(s.valid_low, 4095));
      end
    endcase
    return s;
  endfunction

  // One register write; called at a clock edge with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_TRIGGER:    trig_dist  = data;
      REG_VALID_LOW:  valid_low  = data[SMP_W-1:0];
      REG_VALID_HIGH: valid_high = data[SMP_W-1:0];
      REG_SUBSTITUTE: substitute = data[SMP_W-1:0];
      REG_LOW_LEVEL:  low_level  = data[SMP_W-1:0];
      default: ;
    endcase
  endtask

  // Full register set; junk in the unused upper bits, plus a write to an unmapped index
  task automatic write_settings(settings_t s);
    logic [3:0]           junk;
    logic [CFG_IDX_W-1:0] spare_idx;
    write_reg(REG_TRIGGER, s.trigger);
    junk = 4'($urandom);
    write_reg(REG_VALID_LOW, {junk, s.valid_low});
    junk = 4'($urandom);
    write_reg(REG_VALID_HIGH, {junk, s.valid_high});
    junk = 4'($urandom);
    write_reg(REG_SUBSTITUTE, {junk, s.substitute});
    junk = 4'($urandom);
    write_reg(REG_LOW_LEVEL, {junk, s.low_level});
    spare_idx = CFG_IDX_W'(REG_LOW_LEVEL + 1 + $urandom_range(0, 2));
    write_reg(spare_idx, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Present one packet word, hold it until taken, queue its expected result
  task automatic send_packet(sensor_packet_t p, bit typed, result_t want);
    result_t predicted;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_us_front       <= p.front;
    in_us_left        <= p.left;
    in_us_right       <= p.right;
    in_battery_sample <= p.sample;
    in_seq_id         <= p.id;
    do @(posedge clk); while (!in_ready);
    predicted = supervise_packet(p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic flag_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s at result %0d: expected fresh=%0b obstacle=%0d low_battery=%0b,",
               what, result_idx, want.fresh, want.obstacle, want.low_battery,
               " got fresh=%0b obstacle=%0d low_battery=%0b",
               got.fresh, got.obstacle, got.low_battery);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts while enabled
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each delivered word with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_fresh, out_obstacle_event, out_low_battery};
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", STALE, got);
      end else begin
        want = pending_results.pop_front();
        if (got.fresh !== want.fresh || got.obstacle !== want.obstacle ||
            got.low_battery !== want.low_battery)
          flag_mismatch("result mismatch", want, got);
      end
      result_idx++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_valid          <= 1'b0;
    in_us_front       <= '0;
    in_us_left        <= '0;
    in_us_right       <= '0;
    in_battery_sample <= '0;
    in_seq_id         <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].want);
    last_sent_id = last_id;

    // Random phases; settings change only once the block has drained
    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      write_settings(phase_settings(ph));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == PHASES - 1) begin
          in_idle_on   = 1'b0;
          out_stall_on = 1'b0;
        end else if (n % 50 == 0) begin
          in_idle_on   = ($urandom_range(0, 3) != 0);
          out_stall_on = ($urandom_range(0, 3) != 0);
        end
        send_packet(random_packet(), 1'b0, STALE);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
